// ===== hw/rtl/tsid_pkg.sv =====
`default_nettype none

package tsid_pkg;

	// Result kinds
	localparam logic [2:0] KIND_KEY_ID        = 3'd0;
	localparam logic [2:0] KIND_NAME_LENGTH   = 3'd1;
	localparam logic [2:0] KIND_ENTRY_COUNT   = 3'd2;
	localparam logic [2:0] KIND_NAME_CHAR     = 3'd3;
	localparam logic [2:0] KIND_TYPE_INFO     = 3'd4;
	localparam logic [2:0] KIND_SERVICE_COUNT = 3'd5;
	localparam logic [2:0] KIND_SERVICE_ID    = 3'd6;
	localparam logic [2:0] KIND_END           = 3'd7;

	// End status codes
	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_BAD_TAG    = 3'd1;
	localparam logic [2:0] STAT_ZERO_LEN   = 3'd2;
	localparam logic [2:0] STAT_DATA_SHORT = 3'd3;
	localparam logic [2:0] STAT_OVERRUN    = 3'd4;

	localparam logic [7:0] DEFAULT_TAG      = 8'hCD;
	localparam logic [7:0] NAME_LEN_MASK    = 8'hFC;
	localparam logic [7:0] ENTRY_COUNT_MASK = 8'h03;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] value;
		logic [1:0]  entry;
		logic [7:0]  element;
		logic [2:0]  status;
		logic [8:0]  consumed;
	} result_t;

	// All results caused by one byte; slot 0 goes out first.
	typedef struct packed {
		logic [1:0]        count;
		result_t [2:0]     slot;
	} bundle_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsid_parse.sv =====
`default_nettype none

module tsid_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             first_byte,
	input  wire logic             last_byte,
	input  wire logic [7:0]       expected_tag,
	output tsid_pkg::bundle_t     bundle
);
	import tsid_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_LEN, PH_KEY, PH_NAMEINFO, PH_NAME, PH_TYPE,
		PH_COUNT, PH_SIDHI, PH_SIDLO, PH_SKIP, PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  declared_length_q, declared_length_d;
	logic [7:0]  body_remaining_q, body_remaining_d;
	logic [5:0]  name_remaining_q, name_remaining_d;
	logic [1:0]  entries_remaining_q, entries_remaining_d;
	logic [1:0]  current_entry_q, current_entry_d;
	logic [7:0]  services_remaining_q, services_remaining_d;
	logic [7:0]  element_counter_q, element_counter_d;
	logic [7:0]  service_high_byte_q, service_high_byte_d;

	logic        has_a, has_b, has_end, in_body;
	logic [2:0]  end_status;
	result_t     res_a, res_b, res_end;

	always_comb begin
		phase_d              = phase_q;
		declared_length_d    = declared_length_q;
		body_remaining_d     = body_remaining_q;
		name_remaining_d     = name_remaining_q;
		entries_remaining_d  = entries_remaining_q;
		current_entry_d      = current_entry_q;
		services_remaining_d = services_remaining_q;
		element_counter_d    = element_counter_q;
		service_high_byte_d  = service_high_byte_q;
		has_a      = 1'b0;
		has_b      = 1'b0;
		has_end    = 1'b0;
		in_body    = 1'b0;
		end_status = STAT_OK;
		res_a      = '0;
		res_b      = '0;

		if (first_byte) begin
			declared_length_d    = '0;
			body_remaining_d     = '0;
			name_remaining_d     = '0;
			entries_remaining_d  = '0;
			current_entry_d      = '0;
			services_remaining_d = '0;
			element_counter_d    = '0;
			service_high_byte_d  = '0;
			if (last_byte) begin
				has_end    = 1'b1;
				end_status = STAT_DATA_SHORT;
			end else if (data_byte != expected_tag) begin
				has_end    = 1'b1;
				end_status = STAT_BAD_TAG;
			end else begin
				phase_d = PH_LEN;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE, PH_DONE: begin
				end
				PH_LEN: begin
					declared_length_d = data_byte;
					if (data_byte == 8'd0) begin
						has_end    = 1'b1;
						end_status = STAT_ZERO_LEN;
					end else if (last_byte) begin
						has_end    = 1'b1;
						end_status = STAT_DATA_SHORT;
					end else begin
						body_remaining_d = data_byte;
						phase_d          = PH_KEY;
					end
				end
				PH_KEY: begin
					in_body     = 1'b1;
					has_a       = 1'b1;
					res_a.kind  = KIND_KEY_ID;
					res_a.value = {8'd0, data_byte};
					phase_d     = PH_NAMEINFO;
				end
				PH_NAMEINFO: begin
					in_body             = 1'b1;
					name_remaining_d    = data_byte[7:2];
					entries_remaining_d = data_byte[1:0];
					current_entry_d     = '0;
					element_counter_d   = '0;
					has_a       = 1'b1;
					res_a.kind  = KIND_NAME_LENGTH;
					res_a.value = {8'd0, data_byte & NAME_LEN_MASK} >> 2;
					has_b       = 1'b1;
					res_b.kind  = KIND_ENTRY_COUNT;
					res_b.value = {8'd0, data_byte & ENTRY_COUNT_MASK};
					if (data_byte[7:2] != 6'd0) begin
						phase_d = PH_NAME;
					end else begin
						phase_d = (data_byte[1:0] != 2'd0) ? PH_TYPE : PH_SKIP;
					end
				end
				PH_NAME: begin
					in_body           = 1'b1;
					has_a             = 1'b1;
					res_a.kind        = KIND_NAME_CHAR;
					res_a.value       = {8'd0, data_byte};
					res_a.element     = element_counter_q;
					element_counter_d = element_counter_q + 8'd1;
					name_remaining_d  = name_remaining_q - 6'd1;
					if (name_remaining_d == 6'd0) begin
						phase_d = (entries_remaining_q != 2'd0) ? PH_TYPE : PH_SKIP;
					end
				end
				PH_TYPE: begin
					in_body     = 1'b1;
					has_a       = 1'b1;
					res_a.kind  = KIND_TYPE_INFO;
					res_a.value = {8'd0, data_byte};
					res_a.entry = current_entry_q;
					phase_d     = PH_COUNT;
				end
				PH_COUNT: begin
					in_body              = 1'b1;
					services_remaining_d = data_byte;
					element_counter_d    = '0;
					has_a       = 1'b1;
					res_a.kind  = KIND_SERVICE_COUNT;
					res_a.value = {8'd0, data_byte};
					res_a.entry = current_entry_q;
					if (data_byte != 8'd0) begin
						phase_d = PH_SIDHI;
					end else begin
						entries_remaining_d = entries_remaining_q - 2'd1;
						current_entry_d     = current_entry_q + 2'd1;
						phase_d = (entries_remaining_d != 2'd0) ? PH_TYPE : PH_SKIP;
					end
				end
				PH_SIDHI: begin
					in_body             = 1'b1;
					service_high_byte_d = data_byte;
					phase_d             = PH_SIDLO;
				end
				PH_SIDLO: begin
					in_body              = 1'b1;
					has_a                = 1'b1;
					res_a.kind           = KIND_SERVICE_ID;
					res_a.value          = {service_high_byte_q, data_byte};
					res_a.entry          = current_entry_q;
					res_a.element        = element_counter_q;
					element_counter_d    = element_counter_q + 8'd1;
					services_remaining_d = services_remaining_q - 8'd1;
					if (services_remaining_d != 8'd0) begin
						phase_d = PH_SIDHI;
					end else begin
						entries_remaining_d = entries_remaining_q - 2'd1;
						current_entry_d     = current_entry_q + 2'd1;
						phase_d = (entries_remaining_d != 2'd0) ? PH_TYPE : PH_SKIP;
					end
				end
				PH_SKIP: begin
					in_body = 1'b1;
				end
				default: begin
				end
			endcase

			// Every body byte uses up one byte of the declared length.
			if (in_body) begin
				body_remaining_d = body_remaining_q - 8'd1;
				if (body_remaining_d == 8'd0) begin
					has_end    = 1'b1;
					end_status = (phase_d == PH_SKIP) ? STAT_OK : STAT_OVERRUN;
				end else if (last_byte) begin
					has_end    = 1'b1;
					end_status = STAT_DATA_SHORT;
				end
			end
		end

		if (has_end) begin
			phase_d = PH_DONE;
		end
	end

	always_comb begin
		res_end          = '0;
		res_end.kind     = KIND_END;
		res_end.status   = end_status;
		res_end.consumed = (end_status == STAT_OK) ? 9'd2 + {1'b0, declared_length_d} : 9'd0;

		// Results are packed towards slot 0 in emission order.
		bundle.count   = {1'b0, has_a} + {1'b0, has_b} + {1'b0, has_end};
		bundle.slot[0] = has_a ? res_a : res_end;
		bundle.slot[1] = has_b ? res_b : res_end;
		bundle.slot[2] = res_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q              <= PH_IDLE;
			declared_length_q    <= '0;
			body_remaining_q     <= '0;
			name_remaining_q     <= '0;
			entries_remaining_q  <= '0;
			current_entry_q      <= '0;
			services_remaining_q <= '0;
			element_counter_q    <= '0;
			service_high_byte_q  <= '0;
		end else if (accept) begin
			phase_q              <= phase_d;
			declared_length_q    <= declared_length_d;
			body_remaining_q     <= body_remaining_d;
			name_remaining_q     <= name_remaining_d;
			entries_remaining_q  <= entries_remaining_d;
			current_entry_q      <= current_entry_d;
			services_remaining_q <= services_remaining_d;
			element_counter_q    <= element_counter_d;
			service_high_byte_q  <= service_high_byte_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tsid_outq.sv =====
`default_nettype none

module tsid_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tsid_pkg::bundle_t push_bundle,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output tsid_pkg::result_t      out_result,
	output logic                   out_last
);
	import tsid_pkg::*;

	bundle_t     bundle_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic [1:0]  sel_q;
	logic        pop;
	bundle_t     head;

	assign head       = bundle_q[rd_ptr_q];
	assign full       = (cnt_q == 2'd2);
	assign out_valid  = (cnt_q != 2'd0);
	assign out_result = head.slot[sel_q];
	assign out_last   = (sel_q == head.count - 2'd1);
	assign pop        = out_valid && !out_stall && out_last;

	always_ff @(posedge clk) begin
		if (push) begin
			bundle_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
			sel_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (out_valid && !out_stall) begin
				sel_q <= out_last ? 2'd0 : sel_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ts_information_descriptor_parser.sv =====
// The results of a byte are registered in the result queue and offered in order from there.
// One byte per cycle unless full; the output holds a byte's results until the last is taken.
// A two-entry result queue takes the results of up to two bytes while the output is stalled.
// Reset (arst_n, asynchronous, active low) returns the parser to idle, empties the queue
// and sets the expected tag to 0xCD.
`default_nettype none

module ts_information_descriptor_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       field_kind,
	output logic [15:0]      field_value,
	output logic [1:0]       entry_index,
	output logic [7:0]       element_index,
	output logic [2:0]       status,
	output logic [8:0]       consumed_length,
	output logic             last
);
	import tsid_pkg::*;

	logic [7:0] expected_tag_q;
	logic       accept;
	logic       full;
	bundle_t    bundle;
	result_t    result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tag_q <= DEFAULT_TAG;
		end else if (cfg_we) begin
			expected_tag_q <= cfg_wdata;
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	tsid_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.expected_tag (expected_tag_q),
		.bundle       (bundle)
	);

	tsid_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept && (bundle.count != 2'd0)),
		.push_bundle (bundle),
		.full        (full),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_result  (result),
		.out_last    (last)
	);

	assign field_kind      = result.kind;
	assign field_value     = result.value;
	assign entry_index     = result.entry;
	assign element_index   = result.element;
	assign status          = result.status;
	assign consumed_length = result.consumed;

endmodule

`default_nettype wire

// ===== hw/rtl/tsid_checker.sv =====
`default_nettype none

module tsid_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  field_kind,
	input  wire logic [15:0] field_value,
	input  wire logic [2:0]  status,
	input  wire logic [8:0]  consumed_length,
	input  wire logic        last
);
	import tsid_pkg::*;

	// A stalled result must be held unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(field_kind) && $stable(field_value)
			&& $stable(last))
		else $error("stalled result changed");

	// The end status is always the final result of its byte.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == KIND_END |-> last && field_value == 16'd0)
		else $error("end status not marked last");

	// Only the end status carries a status or a consumed length.
	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind != KIND_END |-> status == STAT_OK && consumed_length == 9'd0)
		else $error("status on a non-end result");

	// The name length is always followed at once by the entry count of the same byte.
	a_name_then_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && field_kind == KIND_NAME_LENGTH
			|-> !last ##1 out_valid && field_kind == KIND_ENTRY_COUNT)
		else $error("entry count did not follow name length");

endmodule

bind ts_information_descriptor_parser tsid_checker u_tsid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.field_kind      (field_kind),
	.field_value     (field_value),
	.status          (status),
	.consumed_length (consumed_length),
	.last            (last)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
import tsid_pkg::*;

typedef struct packed {
	result_t fld;
	logic    last;
} field_rec_t;

typedef struct packed {
	logic [7:0] data;
	logic       first;
	logic       last;
} feed_item_t;

typedef enum logic [3:0] {
	PH_IDLE, PH_LEN, PH_KEY, PH_NAMEINFO, PH_NAME, PH_TYPE,
	PH_COUNT, PH_SIDHI, PH_SIDLO, PH_SKIP, PH_DONE
} desc_phase_t;

class descriptor_scoreboard;
	logic [7:0]  tag;
	desc_phase_t phase;
	logic [7:0]  decl_len;
	logic [7:0]  body_left;
	logic [5:0]  name_left;
	logic [1:0]  ent_left;
	logic [1:0]  cur_ent;
	logic [7:0]  svc_left;
	logic [7:0]  elem_cnt;
	logic [7:0]  sid_hi;
	field_rec_t  expected_fields[$];
	field_rec_t  step_fields[$];
	int          mismatches;

	function new();
		tag = DEFAULT_TAG;
		phase = PH_IDLE;
		clear_counters();
		mismatches = 0;
	endfunction

	function void clear_counters();
		decl_len = 8'd0;
		body_left = 8'd0;
		name_left = 6'd0;
		ent_left = 2'd0;
		cur_ent = 2'd0;
		svc_left = 8'd0;
		elem_cnt = 8'd0;
		sid_hi = 8'd0;
	endfunction

	function void set_tag(logic [7:0] t);
		tag = t;
	endfunction

	function void add_field(logic [2:0] kind, logic [15:0] value, logic [1:0] entry,
			logic [7:0] elem, logic [2:0] stat, logic [8:0] consumed);
		field_rec_t r;
		r.fld.kind = kind;
		r.fld.value = value;
		r.fld.entry = entry;
		r.fld.element = elem;
		r.fld.status = stat;
		r.fld.consumed = consumed;
		r.last = 1'b0;
		step_fields = {step_fields, r};
	endfunction

	function void end_descriptor(logic [2:0] stat);
		add_field(KIND_END, 16'd0, 2'd0, 8'd0, stat,
			(stat == STAT_OK) ? 9'd2 + 9'(decl_len) : 9'd0);
		phase = PH_DONE;
	endfunction

	function void after_list();
		if (ent_left != 2'd0) phase = PH_TYPE;
		else phase = PH_SKIP;
	endfunction

	function void finish_entry();
		ent_left = ent_left - 2'd1;
		cur_ent = cur_ent + 2'd1;
		after_list();
	endfunction

	function void body_byte(logic [7:0] b);
		case (phase)
		PH_KEY: begin
			add_field(KIND_KEY_ID, {8'd0, b}, 2'd0, 8'd0, STAT_OK, 9'd0);
			phase = PH_NAMEINFO;
		end
		PH_NAMEINFO: begin
			name_left = 6'((b & NAME_LEN_MASK) >> 2);
			ent_left = 2'(b & ENTRY_COUNT_MASK);
			cur_ent = 2'd0;
			elem_cnt = 8'd0;
			add_field(KIND_NAME_LENGTH, 16'(name_left), 2'd0, 8'd0, STAT_OK, 9'd0);
			add_field(KIND_ENTRY_COUNT, 16'(ent_left), 2'd0, 8'd0, STAT_OK, 9'd0);
			if (name_left != 6'd0) phase = PH_NAME;
			else after_list();
		end
		PH_NAME: begin
			add_field(KIND_NAME_CHAR, {8'd0, b}, 2'd0, elem_cnt, STAT_OK, 9'd0);
			elem_cnt = elem_cnt + 8'd1;
			name_left = name_left - 6'd1;
			if (name_left == 6'd0) after_list();
		end
		PH_TYPE: begin
			add_field(KIND_TYPE_INFO, {8'd0, b}, cur_ent, 8'd0, STAT_OK, 9'd0);
			phase = PH_COUNT;
		end
		PH_COUNT: begin
			svc_left = b;
			elem_cnt = 8'd0;
			add_field(KIND_SERVICE_COUNT, {8'd0, b}, cur_ent, 8'd0, STAT_OK, 9'd0);
			if (b != 8'd0) phase = PH_SIDHI;
			else finish_entry();
		end
		PH_SIDHI: begin
			sid_hi = b;
			phase = PH_SIDLO;
		end
		PH_SIDLO: begin
			add_field(KIND_SERVICE_ID, {sid_hi, b}, cur_ent, elem_cnt, STAT_OK, 9'd0);
			elem_cnt = elem_cnt + 8'd1;
			svc_left = svc_left - 8'd1;
			if (svc_left != 8'd0) phase = PH_SIDHI;
			else finish_entry();
		end
		default: ;
		endcase
	endfunction

	// Works out the fields that one accepted byte gives rise to.
	function void note_byte(logic [7:0] b, logic first, logic fin);
		step_fields.delete();
		if (first) begin
			clear_counters();
			if (fin) end_descriptor(STAT_DATA_SHORT);
			else if (b != tag) end_descriptor(STAT_BAD_TAG);
			else phase = PH_LEN;
		end else if (phase == PH_LEN) begin
			decl_len = b;
			if (b == 8'd0) end_descriptor(STAT_ZERO_LEN);
			else if (fin) end_descriptor(STAT_DATA_SHORT);
			else begin
				body_left = b;
				phase = PH_KEY;
			end
		end else if (phase != PH_IDLE && phase != PH_DONE) begin
			body_byte(b);
			body_left = body_left - 8'd1;
			if (body_left == 8'd0) end_descriptor((phase == PH_SKIP) ? STAT_OK : STAT_OVERRUN);
			else if (fin) end_descriptor(STAT_DATA_SHORT);
		end
		if (step_fields.size() != 0) step_fields[step_fields.size() - 1].last = 1'b1;
		foreach (step_fields[i]) expected_fields = {expected_fields, step_fields[i]};
	endfunction

	function void report(string what, field_rec_t want, field_rec_t got);
		if (mismatches < 10)
			$display("%s: kind %0d/%0d value %h/%h entry %0d/%0d element %0d/%0d status %0d/%0d consumed %0d/%0d last %0b/%0b (expected/actual)",
				what, want.fld.kind, got.fld.kind, want.fld.value, got.fld.value,
				want.fld.entry, got.fld.entry, want.fld.element, got.fld.element,
				want.fld.status, got.fld.status, want.fld.consumed, got.fld.consumed,
				want.last, got.last);
		mismatches++;
	endfunction

	function void check_field(field_rec_t got);
		field_rec_t want;
		if (expected_fields.size() == 0) begin
			report("unexpected result", '0, got);
		end else begin
			want = expected_fields.pop_front();
			if (got !== want) report("wrong result", want, got);
		end
	endfunction

	function void close_out();
		while (expected_fields.size() != 0)
			report("result never arrived", expected_fields.pop_front(), '0);
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  field_kind;
	logic [15:0] field_value;
	logic [1:0]  entry_index;
	logic [7:0]  element_index;
	logic [2:0]  status;
	logic [8:0]  consumed_length;
	logic        last;

	logic [7:0]  cur_tag = DEFAULT_TAG;
	bit          hold_request = 1'b0;
	bit          quiet = 1'b0;
	int          fed_count = 0;
	feed_item_t  byte_feed[$];
	descriptor_scoreboard sb = new();

	ts_information_descriptor_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.field_kind(field_kind),
		.field_value(field_value),
		.entry_index(entry_index),
		.element_index(element_index),
		.status(status),
		.consumed_length(consumed_length),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_byte(data_byte, first_byte, last_byte);
			if (out_valid && !out_stall)
				sb.check_field({field_kind, field_value, entry_index, element_index,
					status, consumed_length, last});
		end
	end

	// Stall pattern of the result side, with one long hold-off on request.
	initial begin : receiver
		int stall_run;
		int stall_pct;
		stall_run = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				for (int n = 0; n < 80; n++) @(posedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				if (stall_run == 0) begin
					stall_run = $urandom_range(4, 40);
					case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
					endcase
				end
				out_stall <= ($urandom_range(99) < stall_pct);
				stall_run--;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("ts_information_descriptor_parser test failed");
		$finish;
	end

	task automatic push_byte(input logic [7:0] d, input logic f, input logic l, input bit counts);
		byte_feed = {byte_feed, feed_item_t'{d, f, l}};
		if (counts) fed_count++;
	endtask

	task automatic cfg_write(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_tag(v);
		cur_tag = v;
		@(posedge clk);
	endtask

	// Builds random descriptors, mostly well formed, until the item count reaches target.
	task automatic fill_random(input int target);
		logic [7:0] body[$];
		int name_len;
		int n_ent;
		int svc;
		int pick;
		int s;
		int len;
		int stop;
		bit last_on_len;
		bit end_last;
		while (fed_count < target) begin
			body.delete();
			pick = $urandom_range(99);
			if (pick < 80) name_len = $urandom_range(0, 6);
			else if (pick < 90) name_len = $urandom_range(7, 20);
			else name_len = 63;
			n_ent = $urandom_range(0, 3);
			body = {body, 8'($urandom_range(255))};
			body = {body, 8'((name_len << 2) | n_ent)};
			repeat (name_len) body = {body, 8'($urandom_range(255))};
			for (int e = 0; e < n_ent; e++) begin
				body = {body, 8'($urandom_range(255))};
				pick = $urandom_range(99);
				if (pick < 85) svc = $urandom_range(0, 3);
				else if (pick < 95) svc = $urandom_range(4, 12);
				else svc = 255;
				body = {body, 8'(svc)};
				repeat (2 * svc) body = {body, 8'($urandom_range(255))};
			end
			s = body.size();
			pick = $urandom_range(99);
			if (pick < 5) begin
				push_byte(8'($urandom_range(255)), 1'b1, 1'b1, 1'b1);
			end else if (pick < 11) begin
				push_byte(cur_tag ^ 8'($urandom_range(1, 255)), 1'b1, 1'b0, 1'b1);
			end else if (pick < 16) begin
				push_byte(cur_tag, 1'b1, 1'b0, 1'b1);
				push_byte(8'h00, 1'b0, 1'($urandom_range(1)), 1'b1);
			end else begin
				// A declared length shorter than the structure gives an overrun.
				if (pick < 34 || s > 255) len = $urandom_range(1, (s > 256) ? 255 : s - 1);
				else len = s + $urandom_range(0, (s > 252) ? 255 - s : 3);
				while (body.size() < len) body = {body, 8'($urandom_range(255))};
				pick = $urandom_range(99);
				last_on_len = 1'b0;
				end_last = 1'b0;
				stop = len;
				if (pick < 20) begin
					stop = $urandom_range(0, len - 1);
					last_on_len = (stop == 0);
					end_last = 1'b1;
				end else if (pick < 32) begin
					// Abandoned part way; the next tag byte restarts the parser.
					stop = $urandom_range(0, len - 1);
				end else begin
					end_last = $urandom_range(1);
				end
				push_byte(cur_tag, 1'b1, 1'b0, 1'b1);
				push_byte(8'(len), 1'b0, last_on_len, 1'b1);
				for (int i = 0; i < stop; i++)
					push_byte(body[i], 1'b0, end_last && (i == stop - 1), 1'b1);
			end
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 2))
					push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
		end
	endtask

	task automatic send_feed();
		int burst_left;
		burst_left = $urandom_range(1, 20);
		foreach (byte_feed[i]) begin
			in_valid <= 1'b1;
			data_byte <= byte_feed[i].data;
			first_byte <= byte_feed[i].first;
			last_byte <= byte_feed[i].last;
			do @(posedge clk); while (in_stall);
			burst_left--;
			if (!quiet && burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
		in_valid <= 1'b0;
		byte_feed.delete();
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		@(posedge clk);
		while (sb.expected_fields.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed descriptors at the reset tag.
		push_byte(DEFAULT_TAG, 1'b1, 1'b1, 1'b1);
		push_byte(8'h00, 1'b1, 1'b0, 1'b1);
		push_byte(8'h5A, 1'b0, 1'b0, 1'b0);
		push_byte(DEFAULT_TAG, 1'b1, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b1, 1'b1);
		push_byte(DEFAULT_TAG, 1'b1, 1'b0, 1'b1);
		push_byte(8'h07, 1'b0, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b0, 1'b1);
		push_byte(8'h05, 1'b0, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b0, 1'b1);
		push_byte(8'h01, 1'b0, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b1, 1'b1);
		push_byte(DEFAULT_TAG, 1'b1, 1'b0, 1'b1);
		push_byte(8'h05, 1'b0, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0, 1'b1);
		push_byte(8'hFC, 1'b0, 1'b0, 1'b1);
		push_byte(DEFAULT_TAG, 1'b1, 1'b0, 1'b1);
		push_byte(8'h03, 1'b0, 1'b0, 1'b1);
		push_byte(8'h34, 1'b0, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0, 1'b1);
		push_byte(8'h9E, 1'b0, 1'b1, 1'b1);
		push_byte(DEFAULT_TAG, 1'b1, 1'b0, 1'b1);
		push_byte(8'h01, 1'b0, 1'b0, 1'b1);
		push_byte(8'h77, 1'b0, 1'b0, 1'b1);
		push_byte(DEFAULT_TAG, 1'b1, 1'b0, 1'b1);
		push_byte(8'h04, 1'b0, 1'b0, 1'b1);
		push_byte(8'h11, 1'b0, 1'b1, 1'b1);
		fill_random(100);
		send_feed();
		wait_idle();

		// The result side holds off for a long stretch so that the input stalls.
		cfg_write(8'h00);
		hold_request = 1'b1;
		fill_random(180);
		send_feed();
		wait_idle();

		cfg_write(8'hFF);
		quiet = 1'b1;
		fill_random(260);
		send_feed();
		wait_idle();
		quiet = 1'b0;

		cfg_write(8'($urandom_range(1, 254)));
		fill_random(340);
		send_feed();
		wait_idle();

		sb.close_out();
		if (sb.mismatches == 0) $display("ts_information_descriptor_parser test passed");
		else $display("ts_information_descriptor_parser test failed");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/tsid_pkg.sv
hw/rtl/tsid_parse.sv
hw/rtl/tsid_outq.sv
hw/rtl/ts_information_descriptor_parser.sv
hw/rtl/tsid_checker.sv
tb/sv/tb.sv
